// ===== hdl/wlml_pkg.sv =====
// ----------------------------------------------------------------------------
// wlml_pkg: shared types and constants for the window local minimum labeler
// Field widths, configuration register indexes and sample limits.
// ----------------------------------------------------------------------------
package wlml_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int LABEL_W         = 32;
  localparam int WIN_SIZE_W      = 3;
  localparam int MASK_W          = 49;
  localparam int CFG_W           = 49;
  localparam int CFG_IDX_W       = 2;
  localparam int DEF_MAX_WINDOW  = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIN_SIZE   = 2'd0,
    REG_MASK_BITS  = 2'd1,
    REG_ALLOW_EQ   = 2'd2,
    REG_SEQ_MODE   = 2'd3
  } cfg_reg_t;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [LABEL_W-1:0]         LABEL_TOP  = {LABEL_W{1'b1}};
  localparam logic [LABEL_W-1:0]         LABEL_ONE  = LABEL_W'(1);

  // true when neighbor v rules out center c
  function automatic logic disqualifies(input logic signed [SAMPLE_W-1:0] v,
                                        input logic signed [SAMPLE_W-1:0] c,
                                        input logic                       allow_eq);
    disqualifies = allow_eq ? (v < c) : (v <= c);
  endfunction

endpackage

// ===== hdl/window_local_minimum_labeler.sv =====
// ----------------------------------------------------------------------------
// window_local_minimum_labeler
// Streams one square window per result, row order, and labels the center
// sample when it is a local minimum of the neighbors picked by the mask.
// ----------------------------------------------------------------------------
// A window's label is loaded on its last beat and is valid in the next cycle.
// Throughput: one sample beat per cycle, but a beat at or past the last stored
//   position stalls while a label waits; each beat only compares and updates a
//   few registers, and the label register frees up in the same cycle it is taken.
// Reset (rst, synchronous, active high): config returns to 3x3 window, full
//   mask, strict compare, constant labels; position 0, counter 1, no label.
module window_local_minimum_labeler #(
  parameter int MAX_WINDOW = wlml_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [wlml_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wlml_pkg::CFG_W-1:0]          cfg_data,
  // sample beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [wlml_pkg::SAMPLE_W-1:0] sample,
  input  logic                                window_start,
  // label beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wlml_pkg::LABEL_W-1:0]        label
);
  import wlml_pkg::*;

  // window positions run 0 .. MAX_WINDOW^2-1
  localparam int POS_W = $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam logic [WIN_SIZE_W-1:0] MAX_SIDE = WIN_SIZE_W'(MAX_WINDOW);
  localparam logic [WIN_SIZE_W-1:0] MIN_SIDE = WIN_SIZE_W'(3);

  // configuration registers
  logic [WIN_SIZE_W-1:0] win_size;
  logic [MASK_W-1:0]     mask_bits;
  logic                  allow_equals;
  logic                  sequential_mode;

  // window state
  logic [POS_W-1:0]           window_position;
  logic signed [SAMPLE_W-1:0] center_value;
  logic signed [SAMPLE_W-1:0] neighbor_minimum;
  logic                       strict_lower_seen;
  logic                       pre_neighbor_seen; // valid flag for neighbor_minimum
  logic [LABEL_W-1:0]         label_counter;

  // next values
  logic [POS_W-1:0]           window_position_next;
  logic signed [SAMPLE_W-1:0] center_value_next;
  logic signed [SAMPLE_W-1:0] neighbor_minimum_next;
  logic                       strict_lower_seen_next;
  logic                       pre_neighbor_seen_next;
  logic [LABEL_W-1:0]         label_counter_next;
  logic [LABEL_W-1:0]         label_next;

  logic [WIN_SIZE_W-1:0] side;
  logic [POS_W-1:0]      last_pos;
  logic [POS_W-1:0]      center_pos;
  logic [POS_W-1:0]      pos;
  logic                  in_beat;
  logic                  win_done;
  logic                  mask_hit;

  // Effective side: clamp to 3..MAX_WINDOW, drop even sizes by one.
  always_comb begin
    side = win_size;
    if (side < MIN_SIDE) side = MIN_SIDE;
    if (side > MAX_SIDE) side = MAX_SIDE;
    if (!side[0]) side = side - WIN_SIZE_W'(1);
  end

  assign last_pos   = POS_W'(side) * POS_W'(side) - POS_W'(1);
  assign center_pos = last_pos >> 1;

  // A beat can close a window only if the stored position already sits at
  // or past the last index; window_start forces position 0, never the last.
  // Nothing is taken while in reset.
  assign in_ready = !rst && (!out_valid || out_ready || (window_position < last_pos));
  assign in_beat  = in_valid && in_ready;

  assign pos      = window_start ? '0 : window_position;
  assign win_done = (pos >= last_pos);
  assign mask_hit = (32'(pos) < MASK_W) && mask_bits[pos];

  always_comb begin
    center_value_next = center_value;
    label_counter_next = label_counter;
    label_next = '0;

    // first position of a window starts from a clean slate
    if (pos == '0) begin
      neighbor_minimum_next  = SAMPLE_MAX;
      strict_lower_seen_next = 1'b0;
      pre_neighbor_seen_next = 1'b0;
    end else begin
      neighbor_minimum_next  = neighbor_minimum;
      strict_lower_seen_next = strict_lower_seen;
      pre_neighbor_seen_next = pre_neighbor_seen;
    end

    if (pos == center_pos) begin
      // center: check it against the neighbors gathered before it
      center_value_next = sample;
      if (pre_neighbor_seen_next &&
          disqualifies(neighbor_minimum_next, sample, allow_equals))
        strict_lower_seen_next = 1'b1;
    end else if (mask_hit) begin
      if (pos < center_pos) begin
        pre_neighbor_seen_next = 1'b1;
        if (sample < neighbor_minimum_next) neighbor_minimum_next = sample;
      end else if (disqualifies(sample, center_value, allow_equals)) begin
        strict_lower_seen_next = 1'b1;
      end
    end

    if (win_done) begin
      if (strict_lower_seen_next) begin
        label_next = '0;
      end else if (sequential_mode) begin
        label_next = label_counter;
        if (label_counter != LABEL_TOP) label_counter_next = label_counter + LABEL_ONE;
      end else begin
        label_next = LABEL_ONE;
      end
      window_position_next   = '0;
      neighbor_minimum_next  = SAMPLE_MAX;
      strict_lower_seen_next = 1'b0;
      pre_neighbor_seen_next = 1'b0;
    end else begin
      window_position_next = pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size          <= WIN_SIZE_W'(3);
      mask_bits         <= MASK_W'(511);
      allow_equals      <= 1'b0;
      sequential_mode   <= 1'b0;
      window_position   <= '0;
      center_value      <= '0;
      neighbor_minimum  <= SAMPLE_MAX;
      strict_lower_seen <= 1'b0;
      pre_neighbor_seen <= 1'b0;
      label_counter     <= LABEL_ONE;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIN_SIZE:  win_size        <= cfg_data[WIN_SIZE_W-1:0];
          REG_MASK_BITS: mask_bits       <= cfg_data[MASK_W-1:0];
          REG_ALLOW_EQ:  allow_equals    <= cfg_data[0];
          REG_SEQ_MODE:  sequential_mode <= cfg_data[0];
          default: ;
        endcase
      end

      if (in_beat) begin
        window_position   <= window_position_next;
        center_value      <= center_value_next;
        neighbor_minimum  <= neighbor_minimum_next;
        strict_lower_seen <= strict_lower_seen_next;
        pre_neighbor_seen <= pre_neighbor_seen_next;
        label_counter     <= label_counter_next;
      end

      // label register: load on a closing beat, else drain when taken
      if (in_beat && win_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // label payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_beat && win_done) begin
      label <= label_next;
    end
  end

endmodule

// ===== hdl/wlml_checker.sv =====
// ----------------------------------------------------------------------------
// wlml_checker: port-level checks for window_local_minimum_labeler
// Watches the handshakes and the label register over time.
// ----------------------------------------------------------------------------
module wlml_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 window_start,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [wlml_pkg::LABEL_W-1:0]         label
);
  import wlml_pkg::*;

  // reset empties the label register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("label valid after reset");

  // a stalled label holds
  a_label_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(label)))
    else $error("label dropped or changed while stalled");

  // a new label only follows a closing beat, never a window_start beat
  a_label_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && !window_start))
    else $error("label without a closing sample beat");

  // an empty label register, or a label being taken, never blocks the input
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free label register");

endmodule

bind window_local_minimum_labeler wlml_checker u_wlml_checker (.*);
